/* rtl/slr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the servo slew-rate limiter.
// No dependencies; used by every module in rtl/.
package slr_pkg;

	localparam int NUM_CH            = 3;
	localparam int MOTOR_CHANNEL_DEF = 1;

	localparam logic [15:0] PULSE_RESET = 16'd6000;
	localparam logic [15:0] CLAMP_HI    = 16'd10000;
	localparam logic [15:0] CLAMP_LO    = 16'd2000;
	localparam logic [7:0]  SIGN_BIT    = 8'h80;
	localparam logic [7:0]  MAG_MASK    = 8'h7f;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Command modes
	typedef enum logic [2:0] {
		MODE_TICK     = 3'd0,
		MODE_NEUTRAL  = 3'd1,
		MODE_MODIFY   = 3'd2,
		MODE_FWD_THR  = 3'd3,
		MODE_BACK_THR = 3'd4,
		MODE_INIT_FWD = 3'd5,
		MODE_INIT_BCK = 3'd6
	} mode_t;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_PULSE_MIN     = 3'd0,
		REG_PULSE_MAX     = 3'd1,
		REG_PULSE_NEUTRAL = 3'd2,
		REG_FORWARD_BASE  = 3'd3,
		REG_REVERSE_BASE  = 3'd4,
		REG_SLEW_RATE_0   = 3'd5,
		REG_SLEW_RATE_1   = 3'd6,
		REG_SLEW_RATE_2   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] pulse_min;
		logic [15:0] pulse_max;
		logic [15:0] pulse_neutral;
		logic [15:0] forward_base;
		logic [15:0] reverse_base;
		logic [7:0]  slew_rate_0;
		logic [7:0]  slew_rate_1;
		logic [7:0]  slew_rate_2;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  channel;
		logic [7:0]  offset;
	} cmd_item_t;

	typedef struct packed {
		logic [15:0] pulse_0;
		logic [15:0] pulse_1;
		logic [15:0] pulse_2;
		logic        pulse_load;
		logic [15:0] motor_target;
	} res_item_t;

	// Sign-magnitude nudge of a target: add while below hi, subtract while above lo
	function automatic logic [15:0] modify_target(
		input logic [15:0] t,
		input logic [7:0]  off,
		input logic [15:0] lo,
		input logic [15:0] hi
	);
		logic [15:0] r;
		r = t;
		if ((off & SIGN_BIT) == 8'h00) begin
			if (t < hi) r = t + {8'h00, off};
		end else begin
			if (t > lo) r = t - {8'h00, off & MAG_MASK};
		end
		return r;
	endfunction

	// One tick of slew limiting for one channel
	function automatic logic [15:0] slew_step(
		input logic [15:0] c,
		input logic [15:0] t,
		input logic [7:0]  rate
	);
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] r16;
		r16 = {8'h00, rate};
		if (rate == 8'h00) begin
			c2 = t;
		end else begin
			c1 = (t > c) ? c + r16 : c;
			c2 = (t < c1) ? c1 - r16 : c1;
			if (c2 > CLAMP_HI) c2 = CLAMP_HI;
			if (c2 < CLAMP_LO) c2 = CLAMP_LO;
		end
		return c2;
	endfunction

endpackage

/* rtl/servo_slew_rate_limiter.sv */
// Servo slew-rate limiter, three channels, top level.
// Pipeline: input register, command logic, result register.
// Throughput: one item per cycle while no held result (res_stall) blocks the result slot.
// Reset (arst_n low, asynchronous): widths and targets go to 6000, registers to defaults.
// Depends on slr_pkg, slr_regs, slr_core.
`timescale 1ns / 1ps
module servo_slew_rate_limiter #(
	parameter int MOTOR_CHANNEL = slr_pkg::MOTOR_CHANNEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [slr_pkg::PADDR_W-1:0] paddr,
	input  logic [slr_pkg::PDATA_W-1:0] pwdata,
	output logic [slr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  slr_pkg::cmd_item_t          cmd,
	output logic                        res_valid,
	input  logic                        res_stall,
	output slr_pkg::res_item_t          res
);

	slr_pkg::cfg_t      cfg;
	slr_pkg::cmd_item_t cmd_s1;
	logic               valid_s1;
	slr_pkg::res_item_t res_next;
	slr_pkg::res_item_t res_q;
	logic               res_valid_q;
	logic               adv;
	logic               go;

	slr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slr_core #(
		.MOTOR_CHANNEL (MOTOR_CHANNEL)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.go       (go),
		.item     (cmd_s1),
		.res_next (res_next)
	);

	// Handshake: result slot free or draining this cycle
	assign adv       = !res_valid_q || !res_stall;
	assign go        = valid_s1 && adv;
	assign cmd_stall = valid_s1 && !adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_next;
		end
	end

`ifndef NO_ASSERTIONS
	// Input only backs up when a result is held by the consumer
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (res_valid && res_stall))
		else $error("cmd_stall without a held result");

	// A processed item always lands in the result register with the right tick flag
	a_result_tick: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (res_valid && (res.pulse_load == ($past(cmd_s1.mode) == slr_pkg::MODE_TICK))))
		else $error("result missing or pulse_load wrong");

	// A blocked item stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("input item lost while stalled");
`endif

endmodule

/* rtl/slr_regs.sv */
`timescale 1ns / 1ps
// APB-style configuration register file for the servo slew-rate limiter.
// Depends on slr_pkg.
module slr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [slr_pkg::PADDR_W-1:0] paddr,
	input  logic [slr_pkg::PDATA_W-1:0] pwdata,
	output logic [slr_pkg::PDATA_W-1:0] prdata,
	output logic                       pready,
	output slr_pkg::cfg_t              cfg
);

	slr_pkg::cfg_t     cfg_q;
	slr_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = slr_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min     <= 16'd4000;
			cfg_q.pulse_max     <= 16'd8000;
			cfg_q.pulse_neutral <= 16'd6000;
			cfg_q.forward_base  <= 16'd6000;
			cfg_q.reverse_base  <= 16'd6000;
			cfg_q.slew_rate_0   <= 8'd0;
			cfg_q.slew_rate_1   <= 8'd0;
			cfg_q.slew_rate_2   <= 8'd0;
		end else if (wr_en) begin
			unique case (idx)
				slr_pkg::REG_PULSE_MIN:     cfg_q.pulse_min     <= pwdata[15:0];
				slr_pkg::REG_PULSE_MAX:     cfg_q.pulse_max     <= pwdata[15:0];
				slr_pkg::REG_PULSE_NEUTRAL: cfg_q.pulse_neutral <= pwdata[15:0];
				slr_pkg::REG_FORWARD_BASE:  cfg_q.forward_base  <= pwdata[15:0];
				slr_pkg::REG_REVERSE_BASE:  cfg_q.reverse_base  <= pwdata[15:0];
				slr_pkg::REG_SLEW_RATE_0:   cfg_q.slew_rate_0   <= pwdata[7:0];
				slr_pkg::REG_SLEW_RATE_1:   cfg_q.slew_rate_1   <= pwdata[7:0];
				slr_pkg::REG_SLEW_RATE_2:   cfg_q.slew_rate_2   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			slr_pkg::REG_PULSE_MIN:     prdata = {16'h0000, cfg_q.pulse_min};
			slr_pkg::REG_PULSE_MAX:     prdata = {16'h0000, cfg_q.pulse_max};
			slr_pkg::REG_PULSE_NEUTRAL: prdata = {16'h0000, cfg_q.pulse_neutral};
			slr_pkg::REG_FORWARD_BASE:  prdata = {16'h0000, cfg_q.forward_base};
			slr_pkg::REG_REVERSE_BASE:  prdata = {16'h0000, cfg_q.reverse_base};
			slr_pkg::REG_SLEW_RATE_0:   prdata = {24'h000000, cfg_q.slew_rate_0};
			slr_pkg::REG_SLEW_RATE_1:   prdata = {24'h000000, cfg_q.slew_rate_1};
			slr_pkg::REG_SLEW_RATE_2:   prdata = {24'h000000, cfg_q.slew_rate_2};
			default:                    prdata = '0;
		endcase
	end

endmodule

/* rtl/slr_core.sv */
`timescale 1ns / 1ps
// Channel state (targets and current widths) and the single-pass command logic.
// Depends on slr_pkg.
module slr_core #(
	parameter int MOTOR_CHANNEL = slr_pkg::MOTOR_CHANNEL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slr_pkg::cfg_t      cfg,
	input  logic               go,
	input  slr_pkg::cmd_item_t item,
	output slr_pkg::res_item_t res_next
);

	localparam logic [1:0] MotorIdx = 2'(MOTOR_CHANNEL % slr_pkg::NUM_CH);

	logic [15:0] tgt_q [slr_pkg::NUM_CH];
	logic [15:0] cur_q [slr_pkg::NUM_CH];
	logic [15:0] tgt_d [slr_pkg::NUM_CH];
	logic [15:0] cur_d [slr_pkg::NUM_CH];
	logic [7:0]  rate  [slr_pkg::NUM_CH];
	logic        ch_ok;
	logic [15:0] mot_t;

	assign rate[0] = cfg.slew_rate_0;
	assign rate[1] = cfg.slew_rate_1;
	assign rate[2] = cfg.slew_rate_2;
	assign ch_ok   = (item.channel < 2'(slr_pkg::NUM_CH));
	assign mot_t   = tgt_q[MotorIdx];

	// Next state for one command item
	always_comb begin
		tgt_d = tgt_q;
		cur_d = cur_q;
		unique case (item.mode)
			slr_pkg::MODE_TICK: begin
				for (int i = 0; i < slr_pkg::NUM_CH; i++) begin
					cur_d[i] = slr_pkg::slew_step(cur_q[i], tgt_q[i], rate[i]);
				end
			end
			slr_pkg::MODE_NEUTRAL: begin
				if (ch_ok) tgt_d[item.channel] = cfg.pulse_neutral;
			end
			slr_pkg::MODE_MODIFY: begin
				if (ch_ok) begin
					tgt_d[item.channel] = slr_pkg::modify_target(tgt_q[item.channel],
						item.offset, cfg.pulse_min, cfg.pulse_max);
				end
			end
			slr_pkg::MODE_FWD_THR: begin
				tgt_d[MotorIdx] = slr_pkg::modify_target(mot_t, item.offset,
					cfg.pulse_neutral, cfg.pulse_max);
			end
			slr_pkg::MODE_BACK_THR: begin
				// sign bit set moves up toward neutral, clear moves down
				if ((item.offset & slr_pkg::SIGN_BIT) != 8'h00) begin
					if (mot_t < cfg.pulse_neutral)
						tgt_d[MotorIdx] = mot_t + {8'h00, item.offset & slr_pkg::MAG_MASK};
				end else begin
					if (mot_t > cfg.pulse_min)
						tgt_d[MotorIdx] = mot_t - {8'h00, item.offset};
				end
			end
			slr_pkg::MODE_INIT_FWD: tgt_d[MotorIdx] = cfg.forward_base;
			slr_pkg::MODE_INIT_BCK: tgt_d[MotorIdx] = cfg.reverse_base;
			default: ;
		endcase
	end

	// Result: widths before the update, motor target after it
	always_comb begin
		res_next.pulse_0      = cur_q[0];
		res_next.pulse_1      = cur_q[1];
		res_next.pulse_2      = cur_q[2];
		res_next.pulse_load   = (item.mode == slr_pkg::MODE_TICK);
		res_next.motor_target = tgt_d[MotorIdx];
	end

	// Channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < slr_pkg::NUM_CH; i++) begin
				tgt_q[i] <= slr_pkg::PULSE_RESET;
				cur_q[i] <= slr_pkg::PULSE_RESET;
			end
		end else if (go) begin
			tgt_q <= tgt_d;
			cur_q <= cur_d;
		end
	end

endmodule

/* tb/sv/slr_stream_checker.sv */
`timescale 1ns / 1ps
// Stream checker for the servo slew-rate limiter: follows register writes,
// predicts one result item per accepted command item and compares in order.
// Depends on slr_pkg; instantiated beside the block by the bench top.
module slr_stream_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [slr_pkg::PADDR_W-1:0] paddr,
	input  logic [slr_pkg::PDATA_W-1:0] pwdata,
	input  logic                        cmd_valid,
	input  logic                        cmd_stall,
	input  slr_pkg::cmd_item_t          cmd,
	input  logic                        res_valid,
	input  logic                        res_stall,
	input  slr_pkg::res_item_t          res,
	output int                          pending,
	output int                          errors
);

	localparam int          MOTOR        = slr_pkg::MOTOR_CHANNEL_DEF % slr_pkg::NUM_CH;
	localparam int          REPORT_LIMIT = 10;
	localparam logic [15:0] WIDTH_INIT   = 16'd6000;
	localparam logic [15:0] WIDTH_CEIL   = 16'd10000;
	localparam logic [15:0] WIDTH_FLOOR  = 16'd2000;
	localparam logic [7:0]  SUB_FLAG     = 8'h80;
	localparam logic [7:0]  STEP_MASK    = 8'h7f;

	// shadow registers and channel state
	logic [15:0] lim_lo, lim_hi, neutral_w, fwd_base, rev_base;
	logic [7:0]  rate [slr_pkg::NUM_CH];
	logic [15:0] tgt  [slr_pkg::NUM_CH];
	logic [15:0] cur  [slr_pkg::NUM_CH];

	slr_pkg::res_item_t expected_q [$];
	slr_pkg::res_item_t predicted;
	slr_pkg::res_item_t oldest;
	logic               bad;
	int                 n;
	int                 err_count = 0;

	assign errors = err_count;

	// sign-magnitude nudge: add while below hi, subtract low seven bits while above lo
	function automatic logic [15:0] nudge(input logic [15:0] t, input logic [7:0] off,
		input logic [15:0] lo, input logic [15:0] hi);
		logic [15:0] w;
		w = t;
		if ((off & SUB_FLAG) == 8'h00) begin
			if (t < hi) w = t + {8'h00, off};
		end else if (t > lo) begin
			w = t - {8'h00, (off & STEP_MASK)};
		end
		return w;
	endfunction

	// apply one command item to the shadow state, return the result item it causes
	task automatic step_servos(input slr_pkg::cmd_item_t c, output slr_pkg::res_item_t r);
		logic [15:0] w;
		int i;
		r.pulse_0    = cur[0];
		r.pulse_1    = cur[1];
		r.pulse_2    = cur[2];
		r.pulse_load = (c.mode == slr_pkg::MODE_TICK);
		case (c.mode)
			slr_pkg::MODE_TICK: begin
				for (i = 0; i < slr_pkg::NUM_CH; i++) begin
					w = cur[i];
					if (rate[i] != 8'h00) begin
						// up then down, second compare sees the updated width
						if (tgt[i] > w) w = w + {8'h00, rate[i]};
						if (tgt[i] < w) w = w - {8'h00, rate[i]};
						if (w > WIDTH_CEIL) w = WIDTH_CEIL;
						if (w < WIDTH_FLOOR) w = WIDTH_FLOOR;
					end else begin
						w = tgt[i];
					end
					cur[i] = w;
				end
			end
			slr_pkg::MODE_NEUTRAL: begin
				if (c.channel < slr_pkg::NUM_CH) tgt[c.channel] = neutral_w;
			end
			slr_pkg::MODE_MODIFY: begin
				if (c.channel < slr_pkg::NUM_CH)
					tgt[c.channel] = nudge(tgt[c.channel], c.offset, lim_lo, lim_hi);
			end
			slr_pkg::MODE_FWD_THR: begin
				tgt[MOTOR] = nudge(tgt[MOTOR], c.offset, neutral_w, lim_hi);
			end
			slr_pkg::MODE_BACK_THR: begin
				// sign sense is reversed here: flag set adds toward neutral
				if ((c.offset & SUB_FLAG) != 8'h00) begin
					if (tgt[MOTOR] < neutral_w)
						tgt[MOTOR] = tgt[MOTOR] + {8'h00, (c.offset & STEP_MASK)};
				end else if (tgt[MOTOR] > lim_lo) begin
					tgt[MOTOR] = tgt[MOTOR] - {8'h00, c.offset};
				end
			end
			slr_pkg::MODE_INIT_FWD: tgt[MOTOR] = fwd_base;
			slr_pkg::MODE_INIT_BCK: tgt[MOTOR] = rev_base;
			default: ;
		endcase
		r.motor_target = tgt[MOTOR];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_lo    = 16'd4000;
			lim_hi    = 16'd8000;
			neutral_w = 16'd6000;
			fwd_base  = 16'd6000;
			rev_base  = 16'd6000;
			for (n = 0; n < slr_pkg::NUM_CH; n++) begin
				rate[n] = 8'h00;
				tgt[n]  = WIDTH_INIT;
				cur[n]  = WIDTH_INIT;
			end
			expected_q.delete();
			pending <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (slr_pkg::reg_idx_t'(paddr[4:2]))
					slr_pkg::REG_PULSE_MIN:     lim_lo    = pwdata[15:0];
					slr_pkg::REG_PULSE_MAX:     lim_hi    = pwdata[15:0];
					slr_pkg::REG_PULSE_NEUTRAL: neutral_w = pwdata[15:0];
					slr_pkg::REG_FORWARD_BASE:  fwd_base  = pwdata[15:0];
					slr_pkg::REG_REVERSE_BASE:  rev_base  = pwdata[15:0];
					slr_pkg::REG_SLEW_RATE_0:   rate[0]   = pwdata[7:0];
					slr_pkg::REG_SLEW_RATE_1:   rate[1]   = pwdata[7:0];
					slr_pkg::REG_SLEW_RATE_2:   rate[2]   = pwdata[7:0];
					default: ;
				endcase
			end

			// result side first, so a result never matches an item taken this same edge
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("unexpected result item: p0=%0d p1=%0d p2=%0d load=%0b mt=%0d",
							res.pulse_0, res.pulse_1, res.pulse_2, res.pulse_load,
							res.motor_target);
				end else begin
					oldest = expected_q.pop_front();
					bad = (res.pulse_0 !== oldest.pulse_0) ||
						(res.pulse_1 !== oldest.pulse_1) ||
						(res.pulse_2 !== oldest.pulse_2) ||
						(res.pulse_load !== oldest.pulse_load) ||
						(res.motor_target !== oldest.motor_target);
					if (bad) begin
						err_count++;
						if (err_count <= REPORT_LIMIT) begin
							$display("mismatch exp: p0=%0d p1=%0d p2=%0d load=%0b mt=%0d",
								oldest.pulse_0, oldest.pulse_1, oldest.pulse_2,
								oldest.pulse_load, oldest.motor_target);
							$display("         got: p0=%0d p1=%0d p2=%0d load=%0b mt=%0d",
								res.pulse_0, res.pulse_1, res.pulse_2, res.pulse_load,
								res.motor_target);
						end
					end
				end
			end

			// command side
			if (cmd_valid && !cmd_stall) begin
				step_servos(cmd, predicted);
				expected_q.push_back(predicted);
			end

			pending <= expected_q.size();
		end
	end

endmodule

/* tb/sv/servo_slew_rate_limiter_test.sv */
`timescale 1ns / 1ps
// Bench top for the servo slew-rate limiter: clock, reset, register setup,
// command stimulus over idle and stall phases, and the final verdict.
// Depends on slr_pkg, servo_slew_rate_limiter and slr_stream_checker.
module servo_slew_rate_limiter_test;

	localparam int         HALF_PERIOD     = 10;
	localparam int         RESET_CYCLES    = 5;
	localparam int         ITEMS_PER_PHASE = 200;
	localparam int         HOLD_CYCLES     = 400;
	localparam int         DRAIN_CYCLES    = 20;
	localparam int         CYCLE_LIMIT     = 200000;
	localparam logic [2:0] MODE_UNDEF      = 3'd7;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [slr_pkg::PADDR_W-1:0] paddr     = '0;
	logic [slr_pkg::PDATA_W-1:0] pwdata    = '0;
	logic [slr_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	logic                        cmd_valid = 1'b0;
	logic                        cmd_stall;
	slr_pkg::cmd_item_t          cmd       = '0;
	logic                        res_valid;
	logic                        res_stall = 1'b0;
	slr_pkg::res_item_t          res;

	int pending_cnt;
	int fail_cnt;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_reqs     = 0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	servo_slew_rate_limiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	slr_stream_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.pending   (pending_cnt),
		.errors    (fail_cnt)
	);

	// result receiver: random stalls, plus long hold-offs on request
	initial begin : receiver
		int holds_done;
		int k;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs > holds_done) begin
				holds_done++;
				res_stall <= 1'b1;
				for (k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic slr_pkg::cmd_item_t mk(input slr_pkg::mode_t m, input logic [1:0] ch,
		input logic [7:0] off);
		slr_pkg::cmd_item_t c;
		c.mode    = m;
		c.channel = ch;
		c.offset  = off;
		return c;
	endfunction

	// mostly legal modes, ticks frequent, out-of-range channel and undefined mode rare
	function automatic slr_pkg::cmd_item_t rand_cmd();
		slr_pkg::cmd_item_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			c.mode = slr_pkg::MODE_TICK;
		else if (pick < 97)
			c.mode = slr_pkg::mode_t'($urandom_range(6, 1));
		else
			c.mode = slr_pkg::mode_t'(MODE_UNDEF);
		c.channel = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		c.offset  = 8'($urandom_range(255));
		return c;
	endfunction

	function automatic slr_pkg::cfg_t mk_cfg(input logic [15:0] lo, input logic [15:0] hi,
		input logic [15:0] neu, input logic [15:0] fb, input logic [15:0] rb,
		input logic [7:0] r0, input logic [7:0] r1, input logic [7:0] r2);
		slr_pkg::cfg_t k;
		k.pulse_min     = lo;
		k.pulse_max     = hi;
		k.pulse_neutral = neu;
		k.forward_base  = fb;
		k.reverse_base  = rb;
		k.slew_rate_0   = r0;
		k.slew_rate_1   = r1;
		k.slew_rate_2   = r2;
		return k;
	endfunction

	// offer one command item after a random idle gap, return at its accepting edge
	task automatic send_cmd(input slr_pkg::cmd_item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic send_random(input int count);
		int i;
		for (i = 0; i < count; i++) send_cmd(rand_cmd());
	endtask

	// stop offering and wait until every expected result item has come back
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_cnt != 0);
	endtask

	task automatic write_reg(input slr_pkg::reg_idx_t idx,
		input logic [slr_pkg::PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input slr_pkg::cfg_t k);
		write_reg(slr_pkg::REG_PULSE_MIN,     {16'h0000, k.pulse_min});
		write_reg(slr_pkg::REG_PULSE_MAX,     {16'h0000, k.pulse_max});
		write_reg(slr_pkg::REG_PULSE_NEUTRAL, {16'h0000, k.pulse_neutral});
		write_reg(slr_pkg::REG_FORWARD_BASE,  {16'h0000, k.forward_base});
		write_reg(slr_pkg::REG_REVERSE_BASE,  {16'h0000, k.reverse_base});
		write_reg(slr_pkg::REG_SLEW_RATE_0,   {24'h000000, k.slew_rate_0});
		write_reg(slr_pkg::REG_SLEW_RATE_1,   {24'h000000, k.slew_rate_1});
		write_reg(slr_pkg::REG_SLEW_RATE_2,   {24'h000000, k.slew_rate_2});
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, directed items, no idling
		send_cmd(mk(slr_pkg::MODE_TICK,     2'd0, 8'h00));
		send_cmd(mk(slr_pkg::MODE_MODIFY,   2'd0, 8'h7f));
		send_cmd(mk(slr_pkg::MODE_MODIFY,   2'd0, 8'hff));
		send_cmd(mk(slr_pkg::MODE_MODIFY,   2'd1, 8'h00));
		send_cmd(mk(slr_pkg::MODE_MODIFY,   2'd2, 8'h80));
		send_cmd(mk(slr_pkg::MODE_MODIFY,   2'd3, 8'h55));
		send_cmd(mk(slr_pkg::MODE_NEUTRAL,  2'd3, 8'haa));
		send_cmd(mk(slr_pkg::MODE_TICK,     2'd3, 8'hff));
		send_cmd(mk(slr_pkg::MODE_FWD_THR,  2'd0, 8'h7f));
		send_cmd(mk(slr_pkg::MODE_FWD_THR,  2'd2, 8'h81));
		send_cmd(mk(slr_pkg::MODE_BACK_THR, 2'd0, 8'h05));
		send_cmd(mk(slr_pkg::MODE_BACK_THR, 2'd1, 8'h85));
		send_cmd(mk(slr_pkg::MODE_INIT_BCK, 2'd3, 8'h00));
		send_cmd(mk(slr_pkg::MODE_BACK_THR, 2'd0, 8'h85));
		send_cmd(mk(slr_pkg::MODE_BACK_THR, 2'd0, 8'h00));
		send_cmd(mk(slr_pkg::MODE_BACK_THR, 2'd0, 8'hff));
		send_cmd(mk(slr_pkg::MODE_INIT_FWD, 2'd2, 8'hff));
		send_cmd(mk(slr_pkg::MODE_NEUTRAL,  2'd1, 8'h00));
		send_cmd(mk(slr_pkg::MODE_NEUTRAL,  2'd0, 8'h00));
		send_cmd(mk(slr_pkg::MODE_NEUTRAL,  2'd2, 8'h00));
		send_cmd(mk(slr_pkg::mode_t'(MODE_UNDEF), 2'd3, 8'hff));
		send_cmd(mk(slr_pkg::MODE_TICK,     2'd0, 8'h00));
		send_cmd(mk(slr_pkg::MODE_TICK,     2'd0, 8'h00));
		send_random(ITEMS_PER_PHASE);

		// wide-open limits, extreme bases and rates: target wrap and clamps; sender idles
		drain();
		send_idle_pct = 51;
		stall_pct    <= 0;
		apply_cfg(mk_cfg(16'd0, 16'hffff, 16'd0, 16'd65500, 16'd10,
			8'd255, 8'd1, 8'd128));
		send_cmd(mk(slr_pkg::MODE_INIT_FWD, 2'd0, 8'h00));
		send_cmd(mk(slr_pkg::MODE_FWD_THR,  2'd0, 8'hff));
		send_cmd(mk(slr_pkg::MODE_FWD_THR,  2'd0, 8'h7f));
		send_cmd(mk(slr_pkg::MODE_INIT_BCK, 2'd0, 8'h00));
		send_cmd(mk(slr_pkg::MODE_BACK_THR, 2'd0, 8'h7f));
		send_cmd(mk(slr_pkg::MODE_TICK,     2'd0, 8'h00));
		send_random(ITEMS_PER_PHASE);

		// limits that refuse most nudges (reverse throttle can still add toward neutral); receiver stalls
		drain();
		send_idle_pct = 0;
		stall_pct    <= 51;
		apply_cfg(mk_cfg(16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff,
			8'd0, 8'd255, 8'd0));
		send_random(ITEMS_PER_PHASE);

		// random settings; both sides idle a little
		drain();
		send_idle_pct = 14;
		stall_pct    <= 14;
		apply_cfg(mk_cfg(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255))));
		send_random(ITEMS_PER_PHASE);

		// typical settings, no idling, then a long receiver hold-off while items keep coming
		drain();
		send_idle_pct = 0;
		stall_pct    <= 0;
		apply_cfg(mk_cfg(16'd4000, 16'd8000, 16'd6000, 16'd7000, 16'd5000,
			8'd5, 8'd10, 8'd20));
		send_random(ITEMS_PER_PHASE / 2);
		drain();
		hold_reqs <= hold_reqs + 1;
		send_random(ITEMS_PER_PHASE / 2);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* servo_slew_rate_limiter.f */
rtl/slr_pkg.sv
rtl/slr_regs.sv
rtl/slr_core.sv
rtl/servo_slew_rate_limiter.sv
tb/sv/slr_stream_checker.sv
tb/sv/servo_slew_rate_limiter_test.sv
